[rtl/trma_pkg.sv]
package trma_pkg;

    // Operation codes of the request.
    localparam logic [1:0] OP_FREE   = 2'd0;
    localparam logic [1:0] OP_ALLOC  = 2'd1;
    localparam logic [1:0] OP_INSERT = 2'd2;

    // Result status codes.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_OVERLAP = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_NOFIT   = 2'd3;

    // Range kind that marks unassigned space.
    localparam logic [1:0] KIND_NONE = 2'd0;

    // Request transfer.
    typedef struct packed {
        logic [1:0]  operation;
        logic [63:0] base_address;
        logic [63:0] length;
        logic [1:0]  range_kind;
        logic [63:0] alignment;
    } trma_in_t;

    // Result transfer.
    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] granted_address;
    } trma_out_t;

    // Sequencer states.
    typedef enum logic [4:0] {
        S_INIT, S_IDLE, S_DONE,
        C_RD, C_LATCH, C_CHK, C_DIV, C_ALN, C_FIT, C_FIT2, C_UPD, C_GAP,
        G_INIT, G_RD, G_LATCH, G_CHK, G_MP, G_MP2, G_MN, G_AD_RD, G_AD_WR, G_RET,
        D_RD, D_WR
    } trma_state_t;

    // Caller of the give-back sequence.
    typedef enum logic [1:0] {
        PH_FREE, PH_GAP, PH_TYPED, PH_UNDO
    } trma_phase_t;

endpackage

[rtl/trma_ram.sv]
module trma_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port and one registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/typed_range_map_allocator_unit.sv]
// Operation: a free scans the table for its neighbors, then merges or moves entries.
// An allocate or insert scans for the first fitting entry, runs the serial remainder for
// each aligned candidate, then frees any gap.
// Throughput: one request at a time; the next is accepted in the cycle its result appears.
// Reset: after aresetn is released the first cycle writes entry 0 (whole space, kind none);
// requests are accepted from the next cycle on.
module typed_range_map_allocator_unit #(
    parameter int MAX_ENTRIES = 64,
    parameter int ADDR_BITS   = 64
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  trma_pkg::trma_in_t   s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output trma_pkg::trma_out_t  m_data
);
    import trma_pkg::*;

    localparam int A     = ADDR_BITS;
    localparam int W     = 2 * A + 2;
    localparam int IDX_W = $clog2(MAX_ENTRIES);
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int DC_W  = $clog2(ADDR_BITS);

    // Control registers.
    trma_state_t state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic m_valid_reg, m_valid_next;

    // Working registers.
    trma_out_t m_data_reg, m_data_next;
    trma_phase_t phase_reg, phase_next;
    logic [CNT_W-1:0] idx_reg, idx_next, ins_reg, ins_next;
    logic [1:0] op_reg, op_next, kind_reg, kind_next, ckind_reg, ckind_next;
    logic [A-1:0] addr_reg, addr_next, size_reg, size_next, align_reg, align_next;
    logic [1:0] cur_kind_reg, cur_kind_next;
    logic [A-1:0] cur_start_reg, cur_start_next, cur_len_reg, cur_len_next;
    logic [A-1:0] diff_reg, diff_next, end_reg, end_next, a_reg, a_next;
    logic [A-1:0] x_reg, x_next, sh_reg, sh_next, rem_reg, rem_next;
    logic [A-1:0] avail_reg, avail_next, gap_reg, gap_next, len_tmp_reg, len_tmp_next;
    logic [DC_W-1:0] dcnt_reg, dcnt_next;
    logic [1:0] gb_kind_reg, gb_kind_next;
    logic [A-1:0] gb_addr_reg, gb_addr_next, gb_size_reg, gb_size_next;
    logic [A-1:0] gb_end_reg, gb_end_next;
    logic gb_active_reg, gb_active_next, hp_reg, hp_next, hn_reg, hn_next;
    logic mn_reg, mn_next;
    logic [1:0] prev_kind_reg, prev_kind_next, nb_kind_reg, nb_kind_next;
    logic [A-1:0] prev_start_reg, prev_start_next, prev_len_reg, prev_len_next;
    logic [A-1:0] prev_end_reg, prev_end_next;
    logic [A-1:0] nb_start_reg, nb_start_next, nb_len_reg, nb_len_next;
    logic [1:0] gbst_reg, gbst_next, st_reg, st_next, res_st_reg, res_st_next;
    logic [A-1:0] res_addr_reg, res_addr_next;

    // Table memory: {kind, start, length} per entry.
    logic ram_we;
    logic [IDX_W-1:0] ram_waddr, ram_raddr;
    logic [W-1:0] ram_wdata, ram_rdata;
    logic [1:0] rd_kind;
    logic [A-1:0] rd_start, rd_len;

    // Helper terms.
    logic [1:0] gi_kind;
    logic [A-1:0] gi_addr, gi_size;
    logic [A:0] rem_shift, rem_sub;
    logic [A-1:0] len_minus;
    logic ovl, mp, mn;
    logic [CNT_W-1:0] idx_inc, idx_dec, ins_dec;

    trma_ram #(
        .WIDTH (W),
        .DEPTH (MAX_ENTRIES)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_kind  = ram_rdata[W-1 -: 2];
    assign rd_start = ram_rdata[2*A-1 -: A];
    assign rd_len   = ram_rdata[A-1:0];

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign idx_inc = idx_reg + CNT_W'(1);
    assign idx_dec = idx_reg - CNT_W'(1);
    assign ins_dec = ins_reg - CNT_W'(1);

    // Serial remainder step and fit terms.
    assign rem_shift = {rem_reg, sh_reg[A-1]};
    assign rem_sub   = rem_shift - {1'b0, align_reg};
    assign len_minus = cur_len_reg - size_reg;

    // Overlap and merge decisions of the give-back sequence.
    assign ovl = (hp_reg && (prev_end_reg > gb_addr_reg)) ||
                 (hn_reg && (gb_end_reg > nb_start_reg));
    assign mp  = hp_reg && (prev_kind_reg == gb_kind_reg) && (prev_end_reg == gb_addr_reg);
    assign mn  = hn_reg && (nb_kind_reg == gb_kind_reg) && (gb_end_reg == nb_start_reg);

    // Operands of a give-back, chosen by its caller.
    always_comb begin
        unique case (phase_reg)
            PH_FREE: begin
                gi_addr = addr_reg;
                gi_size = size_reg;
                gi_kind = kind_reg;
            end
            PH_GAP: begin
                gi_addr = cur_start_reg;
                gi_size = gap_reg;
                gi_kind = ckind_reg;
            end
            PH_TYPED: begin
                gi_addr = a_reg;
                gi_size = size_reg;
                gi_kind = kind_reg;
            end
            default: begin
                gi_addr = a_reg;
                gi_size = size_reg;
                gi_kind = KIND_NONE;
            end
        endcase
    end

    // Sequencer: next state, memory accesses and datapath updates.
    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        m_valid_next = m_valid_reg;
        m_data_next = m_data_reg;
        phase_next = phase_reg;
        idx_next = idx_reg;
        ins_next = ins_reg;
        op_next = op_reg;
        kind_next = kind_reg;
        ckind_next = ckind_reg;
        addr_next = addr_reg;
        size_next = size_reg;
        align_next = align_reg;
        cur_kind_next = cur_kind_reg;
        cur_start_next = cur_start_reg;
        cur_len_next = cur_len_reg;
        diff_next = diff_reg;
        end_next = end_reg;
        a_next = a_reg;
        x_next = x_reg;
        sh_next = sh_reg;
        rem_next = rem_reg;
        avail_next = avail_reg;
        gap_next = gap_reg;
        len_tmp_next = len_tmp_reg;
        dcnt_next = dcnt_reg;
        gb_kind_next = gb_kind_reg;
        gb_addr_next = gb_addr_reg;
        gb_size_next = gb_size_reg;
        gb_end_next = gb_end_reg;
        gb_active_next = gb_active_reg;
        hp_next = hp_reg;
        hn_next = hn_reg;
        mn_next = mn_reg;
        prev_kind_next = prev_kind_reg;
        prev_start_next = prev_start_reg;
        prev_len_next = prev_len_reg;
        prev_end_next = prev_end_reg;
        nb_kind_next = nb_kind_reg;
        nb_start_next = nb_start_reg;
        nb_len_next = nb_len_reg;
        gbst_next = gbst_reg;
        st_next = st_reg;
        res_st_next = res_st_reg;
        res_addr_next = res_addr_reg;
        ram_we = 1'b0;
        ram_waddr = idx_reg[IDX_W-1:0];
        ram_wdata = '0;
        ram_raddr = idx_reg[IDX_W-1:0];

        // The result register empties on a transfer.
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_INIT: begin
                ram_we = 1'b1;
                ram_waddr = '0;
                ram_wdata = {KIND_NONE, {A{1'b0}}, {A{1'b1}}};
                state_next = S_IDLE;
            end
            S_IDLE: begin
                if (s_valid) begin
                    op_next = s_data.operation;
                    addr_next = s_data.base_address[A-1:0];
                    size_next = s_data.length[A-1:0];
                    kind_next = s_data.range_kind;
                    idx_next = '0;
                    unique case (s_data.operation)
                        OP_FREE: begin
                            phase_next = PH_FREE;
                            state_next = G_INIT;
                        end
                        OP_ALLOC: begin
                            ckind_next = s_data.range_kind;
                            align_next = s_data.alignment[A-1:0];
                            state_next = C_RD;
                        end
                        OP_INSERT: begin
                            ckind_next = KIND_NONE;
                            align_next = '0;
                            if (s_data.range_kind == KIND_NONE) begin
                                res_st_next = ST_NOFIT;
                                res_addr_next = '0;
                                state_next = S_DONE;
                            end else begin
                                state_next = C_RD;
                            end
                        end
                        default: begin
                            res_st_next = ST_NOFIT;
                            res_addr_next = '0;
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next.status = res_st_reg;
                    m_data_next.granted_address = 64'(res_addr_reg);
                    state_next = S_IDLE;
                end
            end

            // First-fit scan for allocate and insert.
            C_RD: begin
                if (idx_reg >= count_reg) begin
                    res_st_next = ST_NOFIT;
                    res_addr_next = '0;
                    state_next = S_DONE;
                end else begin
                    state_next = C_LATCH;
                end
            end
            C_LATCH: begin
                cur_kind_next = rd_kind;
                cur_start_next = rd_start;
                cur_len_next = rd_len;
                diff_next = addr_reg - rd_start;
                end_next = rd_start + rd_len;
                state_next = C_CHK;
            end
            C_CHK: begin
                if (cur_kind_reg != ckind_reg) begin
                    idx_next = idx_inc;
                    state_next = C_RD;
                end else if ((addr_reg != '0) && (cur_start_reg > addr_reg)) begin
                    res_st_next = ST_NOFIT;
                    res_addr_next = '0;
                    state_next = S_DONE;
                end else if ((addr_reg != '0) && (cur_len_reg < diff_reg)) begin
                    idx_next = idx_inc;
                    state_next = C_RD;
                end else if ((addr_reg != '0) && (diff_reg > len_minus)) begin
                    res_st_next = ST_NOFIT;
                    res_addr_next = '0;
                    state_next = S_DONE;
                end else begin
                    a_next = (addr_reg != '0) ? addr_reg : cur_start_reg;
                    x_next = a_next + align_reg - A'(1);
                    sh_next = x_next;
                    rem_next = '0;
                    dcnt_next = '0;
                    state_next = (align_reg != '0) ? C_DIV : C_FIT;
                end
            end
            C_DIV: begin
                // One quotient bit per cycle; only the remainder is kept.
                rem_next = (rem_shift >= {1'b0, align_reg}) ? rem_sub[A-1:0] : rem_shift[A-1:0];
                sh_next = sh_reg << 1;
                dcnt_next = dcnt_reg + DC_W'(1);
                if (dcnt_reg == DC_W'(A - 1)) begin
                    state_next = C_ALN;
                end
            end
            C_ALN: begin
                a_next = x_reg - rem_reg;
                state_next = C_FIT;
            end
            C_FIT: begin
                avail_next = end_reg - a_reg;
                state_next = C_FIT2;
            end
            C_FIT2: begin
                if (avail_reg < size_reg) begin
                    idx_next = idx_inc;
                    state_next = C_RD;
                end else begin
                    gap_next = a_reg - cur_start_reg;
                    len_tmp_next = avail_reg - size_reg;
                    state_next = C_UPD;
                end
            end
            C_UPD: begin
                ram_we = 1'b1;
                ram_wdata = {cur_kind_reg, a_reg + size_reg, len_tmp_reg};
                if (len_tmp_reg == '0) begin
                    gb_active_next = 1'b0;
                    state_next = D_RD;
                end else begin
                    state_next = C_GAP;
                end
            end
            C_GAP: begin
                if (gap_reg != '0) begin
                    phase_next = PH_GAP;
                    state_next = G_INIT;
                end else if (op_reg == OP_ALLOC) begin
                    res_st_next = ST_OK;
                    res_addr_next = a_reg;
                    state_next = S_DONE;
                end else begin
                    phase_next = PH_TYPED;
                    state_next = G_INIT;
                end
            end

            // Give-back: locate neighbors, then merge or insert.
            G_INIT: begin
                gb_addr_next = gi_addr;
                gb_size_next = gi_size;
                gb_kind_next = gi_kind;
                gb_end_next = gi_addr + gi_size;
                gb_active_next = 1'b1;
                hp_next = 1'b0;
                hn_next = 1'b0;
                idx_next = '0;
                if (gi_size == '0) begin
                    gbst_next = ST_OK;
                    state_next = G_RET;
                end else begin
                    state_next = G_RD;
                end
            end
            G_RD: begin
                if (idx_reg >= count_reg) begin
                    hn_next = 1'b0;
                    ins_next = idx_reg;
                    state_next = G_CHK;
                end else begin
                    state_next = G_LATCH;
                end
            end
            G_LATCH: begin
                if (rd_start <= gb_addr_reg) begin
                    prev_kind_next = rd_kind;
                    prev_start_next = rd_start;
                    prev_len_next = rd_len;
                    prev_end_next = rd_start + rd_len;
                    hp_next = 1'b1;
                    idx_next = idx_inc;
                    state_next = G_RD;
                end else begin
                    nb_kind_next = rd_kind;
                    nb_start_next = rd_start;
                    nb_len_next = rd_len;
                    hn_next = 1'b1;
                    ins_next = idx_reg;
                    state_next = G_CHK;
                end
            end
            G_CHK: begin
                if (ovl) begin
                    gbst_next = ST_OVERLAP;
                    state_next = G_RET;
                end else if (mp) begin
                    len_tmp_next = prev_len_reg + gb_size_reg;
                    mn_next = mn;
                    state_next = G_MP;
                end else if (mn) begin
                    state_next = G_MN;
                end else if (count_reg >= CNT_W'(MAX_ENTRIES)) begin
                    gbst_next = ST_FULL;
                    state_next = G_RET;
                end else begin
                    idx_next = count_reg;
                    state_next = G_AD_RD;
                end
            end
            G_MP: begin
                if (mn_reg) begin
                    len_tmp_next = len_tmp_reg + nb_len_reg;
                    state_next = G_MP2;
                end else begin
                    ram_we = 1'b1;
                    ram_waddr = ins_dec[IDX_W-1:0];
                    ram_wdata = {prev_kind_reg, prev_start_reg, len_tmp_reg};
                    gbst_next = ST_OK;
                    state_next = G_RET;
                end
            end
            G_MP2: begin
                ram_we = 1'b1;
                ram_waddr = ins_dec[IDX_W-1:0];
                ram_wdata = {prev_kind_reg, prev_start_reg, len_tmp_reg};
                idx_next = ins_reg;
                state_next = D_RD;
            end
            G_MN: begin
                ram_we = 1'b1;
                ram_waddr = ins_reg[IDX_W-1:0];
                ram_wdata = {nb_kind_reg, nb_start_reg - gb_size_reg, nb_len_reg + gb_size_reg};
                gbst_next = ST_OK;
                state_next = G_RET;
            end
            G_AD_RD: begin
                // Open a hole at the insertion point, top entry first.
                if (idx_reg == ins_reg) begin
                    ram_we = 1'b1;
                    ram_waddr = ins_reg[IDX_W-1:0];
                    ram_wdata = {gb_kind_reg, gb_addr_reg, gb_size_reg};
                    count_next = count_reg + CNT_W'(1);
                    gbst_next = ST_OK;
                    state_next = G_RET;
                end else begin
                    ram_raddr = idx_dec[IDX_W-1:0];
                    state_next = G_AD_WR;
                end
            end
            G_AD_WR: begin
                ram_we = 1'b1;
                ram_wdata = ram_rdata;
                idx_next = idx_dec;
                state_next = G_AD_RD;
            end
            G_RET: begin
                unique case (phase_reg)
                    PH_FREE: begin
                        res_st_next = gbst_reg;
                        res_addr_next = '0;
                        state_next = S_DONE;
                    end
                    PH_GAP: begin
                        if (op_reg == OP_ALLOC) begin
                            res_st_next = ST_OK;
                            res_addr_next = a_reg;
                            state_next = S_DONE;
                        end else begin
                            phase_next = PH_TYPED;
                            state_next = G_INIT;
                        end
                    end
                    PH_TYPED: begin
                        if (gbst_reg == ST_OK) begin
                            res_st_next = ST_OK;
                            res_addr_next = a_reg;
                            state_next = S_DONE;
                        end else begin
                            st_next = gbst_reg;
                            phase_next = PH_UNDO;
                            state_next = G_INIT;
                        end
                    end
                    default: begin
                        res_st_next = st_reg;
                        res_addr_next = '0;
                        state_next = S_DONE;
                    end
                endcase
            end

            // Remove entry idx by moving the entries above it down by one.
            D_RD: begin
                if (idx_inc >= count_reg) begin
                    count_next = count_reg - CNT_W'(1);
                    if (gb_active_reg) begin
                        gbst_next = ST_OK;
                        state_next = G_RET;
                    end else begin
                        state_next = C_GAP;
                    end
                end else begin
                    ram_raddr = idx_inc[IDX_W-1:0];
                    state_next = D_WR;
                end
            end
            D_WR: begin
                ram_we = 1'b1;
                ram_wdata = ram_rdata;
                idx_next = idx_inc;
                state_next = D_RD;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_INIT;
            count_reg <= CNT_W'(1);
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        phase_reg <= phase_next;
        idx_reg <= idx_next;
        ins_reg <= ins_next;
        op_reg <= op_next;
        kind_reg <= kind_next;
        ckind_reg <= ckind_next;
        addr_reg <= addr_next;
        size_reg <= size_next;
        align_reg <= align_next;
        cur_kind_reg <= cur_kind_next;
        cur_start_reg <= cur_start_next;
        cur_len_reg <= cur_len_next;
        diff_reg <= diff_next;
        end_reg <= end_next;
        a_reg <= a_next;
        x_reg <= x_next;
        sh_reg <= sh_next;
        rem_reg <= rem_next;
        avail_reg <= avail_next;
        gap_reg <= gap_next;
        len_tmp_reg <= len_tmp_next;
        dcnt_reg <= dcnt_next;
        gb_kind_reg <= gb_kind_next;
        gb_addr_reg <= gb_addr_next;
        gb_size_reg <= gb_size_next;
        gb_end_reg <= gb_end_next;
        gb_active_reg <= gb_active_next;
        hp_reg <= hp_next;
        hn_reg <= hn_next;
        mn_reg <= mn_next;
        prev_kind_reg <= prev_kind_next;
        prev_start_reg <= prev_start_next;
        prev_len_reg <= prev_len_next;
        prev_end_reg <= prev_end_next;
        nb_kind_reg <= nb_kind_next;
        nb_start_reg <= nb_start_next;
        nb_len_reg <= nb_len_next;
        gbst_reg <= gbst_next;
        st_reg <= st_next;
        res_st_reg <= res_st_next;
        res_addr_reg <= res_addr_next;
    end

    // The table never holds more entries than it has room for.
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_ENTRIES))
        else $error("entry count above table size");

    // Writes land only inside the packed table or on the slot just above it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> ({1'b0, ram_waddr} <= {1'b0, count_reg}))
        else $error("table write beyond the used entries");

    // An accepted request always starts a sequence.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg != S_IDLE))
        else $error("accepted request was not started");

    // The serial remainder stays below the alignment.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == C_DIV) |-> (rem_reg < align_reg))
        else $error("alignment remainder out of range");

endmodule

[verif/typed_range_map_allocator_unit_test.sv]
module typed_range_map_allocator_unit_test;
    import trma_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_DEPTH = 64;
    localparam int WATCHDOG_LIMIT = 60000;
    localparam logic [1:0] KIND_MEMORY = 2'd1;
    localparam logic [1:0] KIND_RESERVED = 2'd2;
    localparam logic [1:0] KIND_DEVICE = 2'd3;
    localparam logic [1:0] OP_UNKNOWN = 2'd3;
    localparam logic [63:0] ALL_ONES = '1;

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    trma_in_t s_data;
    logic m_valid;
    logic m_ready;
    trma_out_t m_data;

    typed_range_map_allocator_unit i_dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data(s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data(m_data)
    );

    // Shadow copy of the range table.
    logic [63:0] map_start [TABLE_DEPTH];
    logic [63:0] map_len [TABLE_DEPTH];
    logic [1:0] map_kind [TABLE_DEPTH];
    int map_count;

    trma_out_t expected_results[$];
    // Granted blocks, kept so that frees can return real allocations.
    trma_in_t granted_blocks[$];
    int mismatches;
    int idle_cycles;
    bit stalls_enabled;
    int stall_left;

    // Clock generation.
    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    function automatic void remove_entry(int j);
        if (j >= map_count) return;
        for (int n = j; n < map_count - 1; n++) begin
            map_start[n] = map_start[n + 1];
            map_len[n] = map_len[n + 1];
            map_kind[n] = map_kind[n + 1];
        end
        map_count--;
    endfunction

    // Returns a range to the table, merging with same-kind neighbors.
    function automatic logic [1:0] release_range(logic [63:0] addr, logic [63:0] size,
                                                 logic [1:0] kind);
        int i;
        bit has_prev;
        bit has_next;
        logic [63:0] prev_end;
        logic [63:0] new_end;
        i = 0;
        if (size == 0) return ST_OK;
        while (i < map_count && map_start[i] <= addr) i++;
        has_prev = i > 0;
        has_next = i < map_count;
        prev_end = has_prev ? map_start[i - 1] + map_len[i - 1] : '0;
        new_end = addr + size;
        if ((has_prev && prev_end > addr) || (has_next && new_end > map_start[i]))
            return ST_OVERLAP;
        if (has_prev && map_kind[i - 1] == kind && prev_end == addr) begin
            map_len[i - 1] = map_len[i - 1] + size;
            if (has_next && map_kind[i] == kind && new_end == map_start[i]) begin
                map_len[i - 1] = map_len[i - 1] + map_len[i];
                remove_entry(i);
            end
            return ST_OK;
        end
        if (has_next && map_kind[i] == kind && new_end == map_start[i]) begin
            map_start[i] = map_start[i] - size;
            map_len[i] = map_len[i] + size;
            return ST_OK;
        end
        if (map_count >= TABLE_DEPTH) return ST_FULL;
        for (int n = map_count; n > i; n--) begin
            map_start[n] = map_start[n - 1];
            map_len[n] = map_len[n - 1];
            map_kind[n] = map_kind[n - 1];
        end
        map_start[i] = addr;
        map_len[i] = size;
        map_kind[i] = kind;
        map_count++;
        return ST_OK;
    endfunction

    // Carves a block of one kind, first fit or at a fixed address.
    function automatic logic [1:0] carve_range(logic [63:0] addr, logic [63:0] size,
                                               logic [1:0] kind, logic [63:0] align,
                                               output logic [63:0] got);
        logic [63:0] a;
        logic [63:0] orig;
        logic [63:0] gap;
        logic [1:0] unused;
        got = '0;
        for (int j = 0; j < map_count; j++) begin
            if (map_kind[j] != kind) continue;
            a = map_start[j];
            if (addr != 0) begin
                if (a > addr) break;
                if (map_len[j] < addr - a) continue;
                if (addr - a > map_len[j] - size) break;
                a = addr;
            end
            if (align != 0) a = ((a + align - 64'd1) / align) * align;
            if (map_start[j] + map_len[j] - a < size) continue;
            orig = map_start[j];
            map_start[j] = a + size;
            map_len[j] = map_len[j] - (a - orig + size);
            if (map_len[j] == 0) remove_entry(j);
            gap = a - orig;
            // A gap that cannot be given back is simply lost.
            if (gap != 0) unused = release_range(orig, gap, kind);
            got = a;
            return ST_OK;
        end
        return ST_NOFIT;
    endfunction

    function automatic trma_out_t predict_result(trma_in_t req);
        trma_out_t res;
        logic [63:0] got;
        logic [1:0] st;
        logic [1:0] unused;
        got = '0;
        case (req.operation)
            OP_FREE: st = release_range(req.base_address, req.length, req.range_kind);
            OP_ALLOC: st = carve_range(req.base_address, req.length, req.range_kind,
                                       req.alignment, got);
            OP_INSERT: begin
                if (req.range_kind == KIND_NONE) begin
                    st = ST_NOFIT;
                end else begin
                    st = carve_range(req.base_address, req.length, KIND_NONE, '0, got);
                    if (st == ST_OK) begin
                        st = release_range(got, req.length, req.range_kind);
                        if (st != ST_OK) unused = release_range(got, req.length, KIND_NONE);
                    end
                end
            end
            default: st = ST_NOFIT;
        endcase
        res.status = st;
        res.granted_address = (st == ST_OK) ? got : '0;
        return res;
    endfunction

    // Sends one request and records its expected result at the transfer.
    task automatic send_request(input logic [1:0] op, input logic [63:0] base,
                                input logic [63:0] len, input logic [1:0] kind,
                                input logic [63:0] align);
        trma_in_t req;
        trma_out_t res;
        req = '{op, base, len, kind, align};
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data <= req;
        do @(posedge aclk); while (!s_ready);
        res = predict_result(req);
        expected_results.push_back(res);
        if (op == OP_ALLOC && res.status == ST_OK && len != 0)
            granted_blocks.push_back('{OP_FREE, res.granted_address, len, kind, '0});
    endtask

    task automatic pause_sender(int cycles);
        @(negedge aclk);
        s_valid <= 1'b0;
        repeat (cycles - 1) @(negedge aclk);
    endtask

    task automatic test_free_cases();
        stalls_enabled = 1'b0;
        send_request(OP_FREE, 64'h1234, '0, KIND_MEMORY, '0);
        send_request(OP_INSERT, 64'h1000, 64'h100, KIND_NONE, '0);
        send_request(OP_UNKNOWN, ALL_ONES, ALL_ONES, KIND_DEVICE, ALL_ONES);
        // Whole space typed, then allocated, which empties the first entry.
        send_request(OP_INSERT, '0, ALL_ONES, KIND_MEMORY, '0);
        send_request(OP_ALLOC, '0, ALL_ONES, KIND_MEMORY, '0);
        send_request(OP_ALLOC, '0, 64'd1, KIND_MEMORY, '0);
        send_request(OP_FREE, '0, ALL_ONES, KIND_NONE, '0);
        send_request(OP_FREE, ALL_ONES, 64'd1, KIND_RESERVED, '0);
        send_request(OP_FREE, 64'h100, 64'h10, KIND_MEMORY, '0);
    endtask

    task automatic test_insert_cases();
        stalls_enabled = 1'b1;
        send_request(OP_INSERT, 64'h1000, 64'h1000, KIND_MEMORY, '0);
        send_request(OP_INSERT, 64'h1800, 64'h10, KIND_DEVICE, '0);
        send_request(OP_INSERT, '0, 64'h100, KIND_RESERVED, '0);
        send_request(OP_INSERT, 64'hFFFF_FFFF_FFFF_FF00, 64'h200, KIND_DEVICE, '0);
        send_request(OP_INSERT, 64'h8000, ALL_ONES, KIND_DEVICE, '0);
    endtask

    task automatic test_alloc_cases();
        send_request(OP_ALLOC, '0, 64'h100, KIND_MEMORY, 64'h300);
        send_request(OP_ALLOC, 64'h1100, 64'h10, KIND_MEMORY, '0);
        send_request(OP_ALLOC, '0, 64'h10, KIND_DEVICE, '0);
        send_request(OP_FREE, 64'h1200, 64'h100, KIND_MEMORY, '0);
        send_request(OP_ALLOC, '0, 64'h10, KIND_NONE, ALL_ONES);
        send_request(OP_ALLOC, 64'h5555_5555_5555_5555, 64'h10, KIND_NONE, 64'h7);
        send_request(OP_ALLOC, '0, ALL_ONES, KIND_NONE, '0);
    endtask

    task automatic test_random_traffic(int count);
        int burst_left;
        int pick;
        logic [1:0] op;
        logic [63:0] base;
        logic [63:0] len;
        logic [1:0] kind;
        logic [63:0] align;
        trma_in_t blk;
        burst_left = 0;
        for (int n = 0; n < count; n++) begin
            if (burst_left == 0) begin
                pause_sender($urandom_range(1, 8));
                burst_left = $urandom_range(1, 12);
                if (n % 200 == 0) stalls_enabled = !stalls_enabled;
            end
            burst_left--;
            pick = $urandom_range(0, 99);
            base = 64'($urandom_range(0, 255) * 16);
            len = 64'($urandom_range(1, 64) * 4);
            kind = 2'($urandom_range(0, 3));
            align = '0;
            if (pick < 35) begin
                op = OP_INSERT;
                if ($urandom_range(0, 3) == 0) base = '0;
                if ($urandom_range(0, 9) == 0) kind = KIND_NONE;
                else kind = 2'($urandom_range(1, 3));
            end else if (pick < 65) begin
                op = OP_ALLOC;
                if ($urandom_range(0, 2) != 0) base = '0;
                case ($urandom_range(0, 4))
                    0: align = 64'd16;
                    1: align = 64'd256;
                    2: align = 64'($urandom_range(1, 100));
                    default: align = '0;
                endcase
            end else if (pick < 95) begin
                op = OP_FREE;
                if (granted_blocks.size() > 0 && $urandom_range(0, 9) < 6) begin
                    blk = granted_blocks[$urandom_range(0, granted_blocks.size() - 1)];
                    base = blk.base_address;
                    len = blk.length;
                    kind = $urandom_range(0, 3) == 0 ? blk.range_kind : kind;
                    if ($urandom_range(0, 1) == 0) len = len / 2;
                end
                if ($urandom_range(0, 19) == 0) len = '0;
            end else begin
                // Noise over the full width of every field.
                op = 2'($urandom_range(0, 3));
                base = {$urandom, $urandom};
                len = {$urandom, $urandom};
                align = {$urandom, $urandom};
            end
            send_request(op, base, len, kind, align);
        end
    endtask

    // Receiver stalls: short random stretches, switched off in some phases.
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            if (stalls_enabled && $urandom_range(0, 5) == 0) stall_left <= $urandom_range(1, 12);
        end
    end

    // Result checking and watchdog.
    always @(posedge aclk) begin
        trma_out_t want;
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("typed_range_map_allocator_unit regression: fail");
                $finish;
            end
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("Unexpected result transfer: %p", m_data);
                end else begin
                    want = expected_results.pop_front();
                    if (m_data.status !== want.status
                        || m_data.granted_address !== want.granted_address) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("Mismatch: expected status %0d address %h, got %0d %h",
                                     want.status, want.granted_address, m_data.status,
                                     m_data.granted_address);
                    end
                end
            end
        end
    end

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        m_ready = 1'b0;
        mismatches = 0;
        idle_cycles = 0;
        stall_left = 0;
        stalls_enabled = 1'b0;
        map_start[0] = '0;
        map_len[0] = ALL_ONES;
        map_kind[0] = KIND_NONE;
        map_count = 1;
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;
        test_free_cases();
        test_insert_cases();
        test_alloc_cases();
        test_random_traffic(1230);
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("typed_range_map_allocator_unit regression: pass");
        end else begin
            $display("typed_range_map_allocator_unit regression: fail");
        end
        $finish;
    end
endmodule
